// File: src/mptd_pkg.sv
// Shared types and codes for the multichannel periodic tick divider.
// Depends on nothing; every other file in the block but mptd_mem imports it.
package mptd_pkg;

    // Action codes carried on the input word.
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_OPEN  = 3'd1,
        ACT_CLOSE = 3'd2,
        ACT_SETF  = 3'd3,
        ACT_POLL  = 3'd4
    } t_action;

    // Status codes returned on the result word.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADF   = 2'd1,
        ST_CLOSED = 2'd2,
        ST_NOTYET = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_READ  = 2'd1,
        S_WRITE = 2'd2
    } t_state;

endpackage

// File: src/mptd_mem.sv
// Channel state memory: one synchronous read port, one write port, registered read data.
// Per-entry valid flops make unwritten entries read back as the reset word.
// Depends on nothing outside this file.
module mptd_mem #(
    parameter int              DEPTH      = 4,
    parameter int              AW         = 2,
    parameter int              W          = 20,
    parameter logic [W-1:0]    RESET_WORD = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_rd_data;
    logic             r_rd_hit;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_valid[i_rd_addr];
        end
    end

    // An entry never written reads as the reset word.
    assign o_rd_data = r_rd_hit ? r_rd_data : RESET_WORD;

endmodule

// File: src/mptd_ctrl.sv
// Read-modify-write sequencer for the channel state memory.
// Depends on mptd_pkg; the per-channel words live in mptd_mem, reached through the memory port.
module mptd_ctrl
    import mptd_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int MAX_FREQ = 512,
    parameter int MIN_FREQ = 2,
    parameter int AW       = 2,
    parameter int DIV_W    = 9,
    parameter int W        = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_action,
    input  logic [1:0]       i_channel,
    input  logic [15:0]      i_frequency,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_status          o_res_status,
    output logic             o_res_fired,
    output logic [AW-1:0]    o_mem_addr,
    input  logic [W-1:0]     i_mem_rd_data,
    output logic             o_mem_wr_en,
    output logic [W-1:0]     o_mem_wr_data
);

    localparam int               DIV0     = MAX_FREQ / MIN_FREQ;
    localparam logic [DIV_W-1:0] DIV_OPEN = DIV_W'(DIV0);
    localparam logic [15:0]      MAXF     = 16'(MAX_FREQ);
    localparam logic [15:0]      MINF     = 16'(MIN_FREQ);
    localparam logic [AW-1:0]    LAST     = AW'(CHANNELS - 1);

    t_state           r_state, n_state;
    t_action          r_action;
    logic             r_inrange;
    logic             r_fok;
    logic [DIV_W-1:0] r_div;
    logic [AW-1:0]    r_addr;

    logic             accept;
    logic             freq_ok;
    logic [3:0]       freq_lg;
    logic             commit;
    logic             step_next;
    logic             e_open, e_fired;
    logic [DIV_W-1:0] e_rel, e_cnt;
    logic             w_open, w_fired;
    logic [DIV_W-1:0] w_rel, w_cnt;

    assign accept     = i_in_valid && o_in_ready;
    assign o_mem_addr = r_addr;

    // Frequency check: a power of two within the allowed range.
    assign freq_ok = (i_frequency != 16'd0) && (i_frequency >= MINF) &&
                     (i_frequency <= MAXF) &&
                     ((i_frequency & (i_frequency - 16'd1)) == 16'd0);

    // Bit position of a one-hot frequency, used as the divider shift.
    always_comb begin
        freq_lg = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (i_frequency[b]) begin
                freq_lg = freq_lg | 4'(b);
            end
        end
    end

    // Unpack the word read back from memory.
    assign e_open  = i_mem_rd_data[W-1];
    assign e_fired = i_mem_rd_data[W-2];
    assign e_rel   = i_mem_rd_data[2*DIV_W-1:DIV_W];
    assign e_cnt   = i_mem_rd_data[DIV_W-1:0];

    // Next state, modified word and result.
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_res_status = ST_OK;
        o_res_fired  = 1'b0;
        o_mem_wr_en  = 1'b0;
        commit       = 1'b0;
        step_next    = 1'b0;
        w_open       = e_open;
        w_fired      = e_fired;
        w_rel        = e_rel;
        w_cnt        = e_cnt;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_action == ACT_TICK) begin
                    if (e_open && !e_fired) begin
                        if (e_cnt <= DIV_W'(1)) begin
                            w_fired = 1'b1;
                        end else begin
                            w_cnt = e_cnt - DIV_W'(1);
                        end
                    end
                    if (r_addr != LAST) begin
                        step_next   = 1'b1;
                        o_mem_wr_en = 1'b1;
                        n_state     = S_READ;
                    end else begin
                        commit = i_out_free;
                        o_mem_wr_en = commit;
                    end
                end else begin
                    commit = i_out_free;
                    if (!r_inrange) begin
                        case (r_action)
                            ACT_OPEN, ACT_CLOSE, ACT_SETF, ACT_POLL: begin
                                o_res_status = ST_CLOSED;
                            end
                            default: begin
                                o_res_status = ST_OK;
                            end
                        endcase
                    end else begin
                        case (r_action)
                            ACT_OPEN: begin
                                w_open      = 1'b1;
                                w_fired     = 1'b0;
                                w_rel       = DIV_OPEN;
                                w_cnt       = DIV_OPEN;
                                o_mem_wr_en = commit;
                            end
                            ACT_CLOSE: begin
                                w_open      = 1'b0;
                                o_mem_wr_en = commit;
                            end
                            ACT_SETF: begin
                                if (!r_fok) begin
                                    o_res_status = ST_BADF;
                                end else if (!e_open) begin
                                    o_res_status = ST_CLOSED;
                                end else begin
                                    w_rel       = r_div;
                                    w_cnt       = r_div;
                                    o_mem_wr_en = commit;
                                end
                            end
                            ACT_POLL: begin
                                if (!e_open) begin
                                    o_res_status = ST_CLOSED;
                                end else if (!e_fired) begin
                                    o_res_status = ST_NOTYET;
                                end else begin
                                    w_fired     = 1'b0;
                                    w_cnt       = e_rel;
                                    o_res_fired = 1'b1;
                                    o_mem_wr_en = commit;
                                end
                            end
                            default: begin
                                o_res_status = ST_OK;
                            end
                        endcase
                    end
                end
                if (commit) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_mem_wr_data = {w_open, w_fired, w_rel, w_cnt};

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item registers, captured when a word is accepted; the address walks during a tick.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= t_action'(i_action);
            r_inrange <= (32'(i_channel) < CHANNELS);
            r_fok     <= freq_ok;
            r_div     <= DIV_W'(MAXF >> freq_lg);
            if (t_action'(i_action) == ACT_TICK) begin
                r_addr <= '0;
            end else begin
                r_addr <= AW'(i_channel);
            end
        end else if (step_next) begin
            r_addr <= r_addr + AW'(1);
        end
    end

endmodule

// File: src/multichannel_periodic_tick_divider_top.sv
// A channel action is taken in the idle state, its channel word is read in the read state, and the
// write state writes back any change and passes the result to the output register. A tick instead
// reads and writes back every channel in turn before its result is passed on. A new word is taken
// only in the idle state, once the sequencer is done with the previous word; a stalled result holds the
// sequencer in its write state. Reset (synchronous, active low) clears the control state and
// the memory valid bits, so every channel reads as closed with the full divider.
module multichannel_periodic_tick_divider_top
    import mptd_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int MAX_FREQ = 512,
    parameter int MIN_FREQ = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_frequency,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_fired
);

    localparam int DIV0  = MAX_FREQ / MIN_FREQ;
    localparam int DIV_W = (DIV0 < 2) ? 1 : $clog2(DIV0 + 1);
    localparam int AW    = (CHANNELS < 2) ? 1 : $clog2(CHANNELS);
    localparam int W     = 2 + 2 * DIV_W;
    localparam logic [W-1:0] RESET_WORD = {1'b0, 1'b0, DIV_W'(DIV0), DIV_W'(DIV0)};

    logic          out_free;
    logic          res_valid;
    t_status       res_status;
    logic          res_fired;
    logic [AW-1:0] mem_addr;
    logic [W-1:0]  mem_rd_data;
    logic          mem_wr_en;
    logic [W-1:0]  mem_wr_data;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic          r_fired;

    assign out_free = !r_out_valid || i_out_ready;

    mptd_ctrl #(
        .CHANNELS (CHANNELS),
        .MAX_FREQ (MAX_FREQ),
        .MIN_FREQ (MIN_FREQ),
        .AW       (AW),
        .DIV_W    (DIV_W),
        .W        (W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_channel      (i_channel),
        .i_frequency    (i_frequency),
        .i_out_free     (out_free),
        .o_res_valid    (res_valid),
        .o_res_status   (res_status),
        .o_res_fired    (res_fired),
        .o_mem_addr     (mem_addr),
        .i_mem_rd_data  (mem_rd_data),
        .o_mem_wr_en    (mem_wr_en),
        .o_mem_wr_data  (mem_wr_data)
    );

    mptd_mem #(
        .DEPTH      (CHANNELS),
        .AW         (AW),
        .W          (W),
        .RESET_WORD (RESET_WORD)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (mem_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_addr),
        .i_wr_data (mem_wr_data)
    );

    // Output register: holds the result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_status <= 2'(res_status);
            r_fired  <= res_fired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_fired     = r_fired;

endmodule

// File: src/mptd_checker.sv
// Port-level checker for the tick divider, bound to the top level.
// Depends on mptd_pkg for the status codes.
module mptd_checker
    import mptd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic        o_fired
);

    logic       in_acc, out_acc;
    logic [2:0] r_pending;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Words accepted but whose result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
        end
    end

    // At most one word in work and one result waiting.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("more words outstanding than the block can hold");

    // No result appears without an accepted word behind it.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 3'd0))
        else $error("result word shown with no word outstanding");

    // A consumed period is always reported with an ok status.
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fired) |-> (o_status == ST_OK))
        else $error("fired result carries a non-ok status");

    // Taking a word closes the input until the sequencer is done with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready straight after accepting a word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_fired)))
        else $error("stalled result word changed or dropped");

endmodule

bind multichannel_periodic_tick_divider_top mptd_checker u_mptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_fired     (o_fired)
);
